// ----- rtl/upn_pkg.sv -----
// Package for the URI path normalizer: segment modes, phases, status codes,
// byte class table and hex decode. No dependencies.
package upn_pkg;

  localparam int unsigned MaxTargetDefault = 4096;
  localparam int unsigned QueueDepth       = 2;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_SLASH  = 3'd1,
    M_DOT    = 3'd2,
    M_DOTDOT = 3'd3,
    M_Q1     = 3'd4,
    M_Q2     = 3'd5
  } seg_mode_e;

  typedef enum logic [1:0] {
    P_PATH = 2'd0,
    P_ARGS = 2'd1,
    P_HASH = 2'd2,
    P_BAD  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_EXEC = 2'd1,
    B_SCAN = 2'd2,
    B_OUT  = 2'd3
  } back_state_e;

  localparam logic [63:0] PlainMap = 64'h7FFF_37D6_FFFF_DBFE;

  // Word handed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       keep;
  } item_t;

  function automatic logic is_plain(input logic [7:0] c);
    logic r;
    if (c[7:6] != 2'b00) r = 1'b1;
    else r = PlainMap[c[5:0]];
    return r;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [7:0] c;
    logic [4:0] r;
    c = ch | 8'h20;
    r = 5'h10;
    if (ch >= "0" && ch <= "9") r = {1'b0, ch[3:0]};
    else if (c >= "a" && c <= "f") r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ----- rtl/upn_front.sv -----
// Front end of the URI path normalizer: accepts words and queues them.
// Depends on upn_pkg.
module upn_front import upn_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] target_byte_i,
  input  logic       end_of_target_i,
  input  logic       keep_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output item_t      q_item_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  item_t            mem_q [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o = (cnt_q != (Aw+1)'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  // Store the word.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{ch: target_byte_i, last: end_of_target_i, keep: keep_i};
  end

  // Advance the pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(Depth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop on empty");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (Aw+1)'(Depth)) |-> !in_ready_o) else $error("full not stalled");
`endif
endmodule

// ----- rtl/upn_back.sv -----
// Back end of the URI path normalizer: segment state machine, path buffer,
// dot-dot back-up scan and result register. Depends on upn_pkg.
module upn_back import upn_pkg::*; #(
  parameter int unsigned MaxTarget = MaxTargetDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  write_count_o,
  output logic [12:0] write_position_o,
  output logic [7:0]  first_byte_o,
  output logic [7:0]  second_byte_o,
  output logic [7:0]  third_byte_o,
  output logic [12:0] path_length_o,
  output logic        args_found_o,
  output logic [12:0] args_start_o,
  output logic [12:0] args_length_o,
  output logic        quoted_seen_o
);
  localparam int unsigned Pw = $clog2(MaxTarget + 1);
  localparam int unsigned Aw = $clog2(MaxTarget);

  logic [7:0]  store_q [MaxTarget];
  back_state_e st_q, st_d;
  seg_mode_e   mode_q, mode_d, mbe_q, mbe_d;
  phase_e      ph_q, ph_d;
  logic [3:0]  hi_q, hi_d;
  logic [Pw-1:0] pp_q, pp_d, ti_q, ti_d, ab_q, ab_d, ac_q, ac_d;
  logic        af_q, af_d, es_q, es_d, done_q, done_d;
  // Scan: pos register, pending byte after back-up.
  logic [Pw:0] sp_q, sp_d;
  logic [7:0]  rd_q;
  logic        rdv_q;
  logic        sc_end_q, sc_end_d;
  logic [1:0]  sc_act_q, sc_act_d;
  // Results.
  logic [1:0]  wc_q, wc_d;
  logic [Pw-1:0] wp_q, wp_d;
  logic [7:0]  b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  // Store write port.
  logic        we0, we1, we2;
  logic [Pw-1:0] wa0;
  logic        scan_start;

  localparam logic [1:0] ActGo = 2'd0, ActArgs = 2'd1, ActHash = 2'd2;

  // Emit helper: append byte to result slots and buffer.
  function automatic void do_emit(input logic [7:0] b, inout logic [1:0] wc,
      inout logic [Pw-1:0] wp, inout logic [Pw-1:0] pp, inout logic [7:0] s0,
      inout logic [7:0] s1, inout logic [7:0] s2, inout logic e0, inout logic e1,
      inout logic e2);
    if (wc == 2'd0) wp = pp;
    if (pp < Pw'(MaxTarget)) begin
      case (wc)
        2'd0: e0 = 1'b1;
        2'd1: e1 = 1'b1;
        default: e2 = 1'b1;
      endcase
      pp = pp + 1'b1;
    end
    case (wc)
      2'd0: s0 = b;
      2'd1: s1 = b;
      2'd2: s2 = b;
      default: ;
    endcase
    if (wc != 2'd3) wc = wc + 1'b1;
  endfunction

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: if (q_valid_i) st_d = B_EXEC;
      B_EXEC: st_d = scan_start ? B_SCAN : B_OUT;
      B_SCAN: if (rdv_q && (rd_q == "/" || sp_q[Pw])) st_d = B_OUT;
      B_OUT:  if (out_ready_i) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    logic [7:0] ch, d, pb;
    logic [4:0] hv;
    logic       bad, plain_go, back, keep;
    logic [1:0] act;
    seg_mode_e  m;
    logic [Pw-1:0] here;
    mode_d = mode_q; mbe_d = mbe_q; ph_d = ph_q; hi_d = hi_q; pp_d = pp_q;
    ti_d = ti_q; ab_d = ab_q; ac_d = ac_q; af_d = af_q; es_d = es_q;
    done_d = done_q; sp_d = sp_q; sc_end_d = sc_end_q; sc_act_d = sc_act_q;
    wc_d = wc_q; wp_d = wp_q; b0_d = b0_q; b1_d = b1_q; b2_d = b2_q;
    we0 = 1'b0; we1 = 1'b0; we2 = 1'b0; wa0 = pp_q;
    scan_start = 1'b0;
    ch = q_item_i.ch; keep = q_item_i.keep;
    d = '0; pb = '0; hv = '0; bad = 1'b0; plain_go = 1'b0; back = 1'b0;
    act = ActGo; m = mode_q; here = ti_q;
    unique case (st_q)
      B_IDLE: begin
        wc_d = '0; wp_d = '0; b0_d = '0; b1_d = '0; b2_d = '0;
      end
      B_EXEC: begin
        if (!done_q && ph_q != P_BAD) begin
          if (q_item_i.last) begin
            if (ph_q == P_PATH) begin
              if (mode_q == M_Q1 || mode_q == M_Q2) ph_d = P_BAD;
              else if (mode_q == M_DOT) begin
                if (pp_q != '0) pp_d = pp_q - 1'b1;
                mode_d = M_SLASH;
              end else if (mode_q == M_DOTDOT) back = 1'b1;
            end
            if (ph_d != P_BAD && !back) done_d = 1'b1;
            sc_end_d = 1'b1;
          end else if (ti_q >= Pw'(MaxTarget)) begin
            ph_d = P_BAD;
          end else begin
            ti_d = ti_q + 1'b1;
            sc_end_d = 1'b0;
            if (ph_q == P_PATH) begin
              if (mode_q == M_Q1) begin
                es_d = 1'b1;
                hv = hex_val(ch);
                if (hv[4]) bad = 1'b1;
                else begin hi_d = hv[3:0]; mode_d = M_Q2; end
              end else if (mode_q == M_Q2) begin
                hv = hex_val(ch);
                d = {hi_q, hv[3:0]};
                if (hv[4]) bad = 1'b1;
                else if (d == "%" || d == "#" || d == "?") begin
                  mode_d = M_NORMAL;
                  do_emit(d, wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                  if (d == "%" && keep) begin
                    do_emit("2", wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                    do_emit("5", wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                  end
                end else if (d == "/" && keep) begin
                  mode_d = M_NORMAL;
                  do_emit("%", wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                  do_emit("2", wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                  do_emit(ch, wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                end else if (d == 8'h00) bad = 1'b1;
                else begin
                  m = (mbe_q == M_Q1 || mbe_q == M_Q2) ? M_NORMAL : mbe_q;
                  pb = d; plain_go = 1'b1;
                end
              end else begin
                pb = ch; plain_go = 1'b1;
              end
              if (plain_go) begin
                if (is_plain(pb)) begin
                  mode_d = M_NORMAL;
                  do_emit(pb, wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                end else if (pb == "%") begin
                  mbe_d = m; mode_d = M_Q1;
                end else if (pb == "/" || pb == "?" || pb == "#") begin
                  if (pb == "?") act = ActArgs;
                  else if (pb == "#") act = ActHash;
                  if (m == M_DOT) begin
                    if (pp_q != '0) pp_d = pp_q - 1'b1;
                  end else if (m == M_DOTDOT) back = 1'b1;
                  else if (m == M_NORMAL && pb == "/")
                    do_emit("/", wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                  mode_d = (pb == "/") ? M_SLASH : m;
                end else if (pb == "." && (m == M_SLASH || m == M_DOT)) begin
                  mode_d = (m == M_SLASH) ? M_DOT : M_DOTDOT;
                  do_emit(".", wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                end else begin
                  mode_d = M_NORMAL;
                  do_emit(pb, wc_d, wp_d, pp_d, b0_d, b1_d, b2_d, we0, we1, we2);
                end
              end
              if (bad) begin
                ph_d = P_BAD; mode_d = mode_q;
                wc_d = '0; wp_d = '0; b0_d = '0; b1_d = '0; b2_d = '0;
                we0 = 1'b0; we1 = 1'b0; we2 = 1'b0; pp_d = pp_q;
              end else if (!back) begin
                if (act == ActArgs) begin
                  ph_d = P_ARGS; af_d = 1'b1; ab_d = here + 1'b1;
                end else if (act == ActHash) ph_d = P_HASH;
              end
              sc_act_d = act;
            end else if (ph_q == P_ARGS) begin
              if (ch == "#") ph_d = P_HASH;
              else ac_d = ac_q + 1'b1;
            end
          end
          if (back) begin
            scan_start = 1'b1;
            sp_d = {1'b0, pp_q} - (Pw+1)'(5);
          end
        end
      end
      B_SCAN: begin
        // One buffer read a cycle, walking toward the start.
        if (sp_q[Pw]) begin
          if (rdv_q || sp_q[Pw]) begin
            ph_d = P_BAD;
          end
        end else if (rdv_q) begin
          if (rd_q == "/") begin
            pp_d = sp_q[Pw-1:0] + 1'b1;
            if (sc_end_q) begin mode_d = M_SLASH; done_d = 1'b1; end
            else if (sc_act_q == ActArgs) begin
              ph_d = P_ARGS; af_d = 1'b1; ab_d = ti_q;
            end else if (sc_act_q == ActHash) ph_d = P_HASH;
          end else sp_d = sp_q - 1'b1;
        end
      end
      B_OUT: ;
      default: ;
    endcase
  end

  assign q_ready_o = (st_q == B_EXEC);

  // Buffer write and scan read.
  always_ff @(posedge clk_i) begin
    if (we0) store_q[Aw'(wa0)] <= b0_d;
    if (we1) store_q[Aw'(wa0 + 1'b1)] <= b1_d;
    if (we2) store_q[Aw'(wa0 + 2'd2)] <= b2_d;
    rd_q <= store_q[Aw'(sp_d[Pw-1:0])];
  end

  // Hold the state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; mode_q <= M_NORMAL; mbe_q <= M_NORMAL; ph_q <= P_PATH;
      hi_q <= '0; pp_q <= '0; ti_q <= '0; ab_q <= '0; ac_q <= '0;
      af_q <= 1'b0; es_q <= 1'b0; done_q <= 1'b0; sp_q <= '0; rdv_q <= 1'b0;
      sc_end_q <= 1'b0; sc_act_q <= ActGo;
      wc_q <= '0; wp_q <= '0; b0_q <= '0; b1_q <= '0; b2_q <= '0;
    end else begin
      st_q <= st_d; mode_q <= mode_d; mbe_q <= mbe_d; ph_q <= ph_d;
      hi_q <= hi_d; pp_q <= pp_d; ti_q <= ti_d; ab_q <= ab_d; ac_q <= ac_d;
      af_q <= af_d; es_q <= es_d; done_q <= done_d; sp_q <= sp_d;
      // The read address follows sp_d, so the data always matches sp_q.
      rdv_q <= (st_d == B_SCAN);
      sc_end_q <= sc_end_d; sc_act_q <= sc_act_d;
      wc_q <= wc_d; wp_q <= wp_d; b0_q <= b0_d; b1_q <= b1_d; b2_q <= b2_d;
    end
  end

  assign out_valid_o      = (st_q == B_OUT);
  assign status_o         = (ph_q == P_BAD) ? ST_BAD : (done_q ? ST_DONE : ST_BUSY);
  assign write_count_o    = wc_q;
  assign write_position_o = 13'(wp_q);
  assign first_byte_o     = b0_q;
  assign second_byte_o    = b1_q;
  assign third_byte_o     = b2_q;
  assign path_length_o    = 13'(pp_q);
  assign args_found_o     = af_q;
  assign args_start_o     = 13'(ab_q);
  assign args_length_o    = 13'(ac_q);
  assign quoted_seen_o    = es_q;

`ifndef NO_ASSERTIONS
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pp_q <= Pw'(MaxTarget)) else $error("path pointer past buffer");
  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_OUT && ph_q == P_BAD && $past(ph_q) == P_BAD && $past(st_q) != B_SCAN)
      |-> wc_q == 2'd0) else $error("write after invalid");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(wc_q))
    else $error("result dropped");
`endif
endmodule

// ----- rtl/uri_path_normalizer_core.sv -----
// URI path normalizer top: front queue plus back-end executor.
// Each word steps through the back-end sequencer (take, execute, present); the next one
// waits for out_ready_i. A dot-dot back-up adds one buffer read per byte scanned.
// Reset (rst_ni low, async) clears all control state; the path buffer is undefined until
// written and needs no clearing pass.
// Depends on upn_pkg, upn_front, upn_back.
module uri_path_normalizer_core import upn_pkg::*; #(
  parameter int unsigned MaxTarget = MaxTargetDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  target_byte_i,
  input  logic        end_of_target_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  write_count_o,
  output logic [12:0] write_position_o,
  output logic [7:0]  first_byte_o,
  output logic [7:0]  second_byte_o,
  output logic [7:0]  third_byte_o,
  output logic [12:0] path_length_o,
  output logic        args_found_o,
  output logic [12:0] args_start_o,
  output logic [12:0] args_length_o,
  output logic        quoted_seen_o
);
  logic  keep_q;
  logic  q_valid, q_ready;
  item_t q_item;

  // Hold the config register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) keep_q <= 1'b0;
    else if (cfg_valid_i) keep_q <= cfg_data_i;
  end

  upn_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .target_byte_i, .end_of_target_i,
    .keep_i(keep_q), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  upn_back #(.MaxTarget(MaxTarget)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .status_o, .write_count_o, .write_position_o,
    .first_byte_o, .second_byte_o, .third_byte_o, .path_length_o, .args_found_o,
    .args_start_o, .args_length_o, .quoted_seen_o
  );
endmodule
